// ===== hw/rtl/loah_pkg.sv =====
// Shared types, constants and hash functions for the lowercase one-at-a-time hash.
// No dependencies; imported by loah_core, lowercase_one_at_a_time_hash and the testbench.
package loah_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned HASH_W = 32;

    localparam logic [BYTE_W-1:0] TERM_BYTE   = 8'h00;
    localparam logic [BYTE_W-1:0] UPPER_FIRST = 8'h41;
    localparam logic [BYTE_W-1:0] UPPER_LAST  = 8'h5A;
    localparam logic [BYTE_W-1:0] CASE_OFFSET = 8'h20;
    localparam logic [HASH_W-1:0] HASH_MIN    = 32'd2;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [HASH_W-1:0] hash_t;

    // One byte moving from the input register into the hash state.
    typedef struct packed {
        logic  fire;
        byte_t data;
    } step_t;

    function automatic byte_t fold_lower(input byte_t b);
        byte_t r;
        r = b;
        if (b >= UPPER_FIRST && b <= UPPER_LAST)
        begin
            r = b + CASE_OFFSET;
        end
        return r;
    endfunction

    function automatic hash_t mix_byte(input hash_t h, input byte_t b);
        hash_t t;
        t = h + {{(HASH_W-BYTE_W){1'b0}}, fold_lower(b)};
        t = t + (t << 10);
        return t ^ (t >> 6);
    endfunction

    function automatic hash_t finalize(input hash_t v);
        hash_t t;
        t = v + (v << 3);
        t = t ^ (t >> 11);
        t = t + (t << 15);
        if (t < HASH_MIN)
        begin
            t = t + HASH_MIN;
        end
        return t;
    endfunction

endpackage

// ===== hw/rtl/loah_core.sv =====
// Running hash state: mixes one byte per step, finalizes and clears on a terminator.
// Depends on loah_pkg.
module loah_core
    import loah_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  step_t step,
    output hash_t final_hash
);

    hash_t hash_reg;
    hash_t hash_next;

    always_comb
    begin
        hash_next = hash_reg;
        if (step.fire)
        begin
            if (step.data == TERM_BYTE)
            begin
                hash_next = '0;
            end
            else
            begin
                hash_next = mix_byte(hash_reg, step.data);
            end
        end
    end

    assign final_hash = finalize(hash_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= '0;
        end
        else
        begin
            hash_reg <= hash_next;
        end
    end

endmodule

// ===== hw/rtl/lowercase_one_at_a_time_hash.sv =====
// Top level of the lowercase one-at-a-time hash: input register, hash core, result register.
// Depends on loah_pkg and loah_core.
//
//   channel | payload     | handshake            | beat
//   in      | byte_value  | in_valid / in_stall  | one string byte, zero ends the string
//   out     | hash_value  | out_valid / out_stall| one finalized hash per terminator
//
// One byte per cycle sustained while no terminator waits on a stalled result; a byte enters
// the input register, is mixed into the running hash on the next edge, and a terminator's
// hash is registered as it retires. Reset clears the running hash and all valid flags.
// A stalled result holds only a terminator in the input register; other bytes keep flowing.
module lowercase_one_at_a_time_hash
    import loah_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  byte_t byte_value,
    output logic  out_valid,
    input  logic  out_stall,
    output hash_t hash_value
);

    logic  s1_valid_reg;
    logic  s1_valid_next;
    byte_t s1_byte_reg;
    logic  out_valid_reg;
    logic  out_valid_next;
    hash_t out_hash_reg;
    logic  s1_term;
    logic  out_free;
    logic  s1_retire;
    logic  in_take;
    step_t step;
    hash_t final_hash;

    assign s1_term   = (s1_byte_reg == TERM_BYTE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign s1_retire = s1_valid_reg && (!s1_term || out_free);
    assign in_stall  = s1_valid_reg && !s1_retire;
    assign in_take   = in_valid && !in_stall;

    assign step.fire = s1_retire;
    assign step.data = s1_byte_reg;

    loah_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .final_hash (final_hash)
    );

    always_comb
    begin
        s1_valid_next = in_take ? 1'b1 : (s1_retire ? 1'b0 : s1_valid_reg);
        out_valid_next = out_valid_reg && out_stall;
        if (s1_retire && s1_term)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: the byte loads on a taken beat, the hash on a retiring terminator; both hold otherwise.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg <= byte_value;
        end
        if (s1_retire && s1_term)
        begin
            out_hash_reg <= final_hash;
        end
    end

    assign out_valid  = out_valid_reg;
    assign hash_value = out_hash_reg;

    a_term_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_retire && s1_term) |=> out_valid)
        else $error("terminator retired without a result");

    a_hash_min: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (hash_value >= HASH_MIN))
        else $error("result hash below minimum");

    a_stall_term: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && s1_term && out_valid && out_stall))
        else $error("input stalled without a blocked terminator");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_term) |=> !$past(in_stall))
        else $error("data byte blocked the input");

endmodule

// ===== tb/sv/lowercase_one_at_a_time_hash_checker.sv =====
// Checker for the lowercase one-at-a-time hash: watches both channels, predicts each hash.
// Depends on loah_pkg for the byte and hash types.
module lowercase_one_at_a_time_hash_checker
    import loah_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  logic  in_stall,
    input  byte_t byte_value,
    input  logic  out_valid,
    input  logic  out_stall,
    input  hash_t hash_value,
    output int    fail_count,
    output int    pending_hashes,
    output int    hashes_checked
);

    hash_t string_hash;
    hash_t hash_q[$];

    function automatic byte_t to_lower(input byte_t b);
        if (b >= 8'h41 && b <= 8'h5A)
        begin
            return b + 8'h20;
        end
        return b;
    endfunction

    function automatic hash_t absorb_byte(input hash_t h, input byte_t b);
        hash_t t;
        t = h + hash_t'(to_lower(b));
        t = t * 32'd1025;
        return t ^ (t >> 6);
    endfunction

    function automatic hash_t close_hash(input hash_t h);
        hash_t t;
        t = h * 32'd9;
        t = t ^ (t >> 11);
        t = t * 32'd32769;
        if (t < 32'd2)
        begin
            t = t + 32'd2;
        end
        return t;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        hash_t want;
        if (!rst_n)
        begin
            string_hash = '0;
            hash_q.delete();
            fail_count     <= 0;
            pending_hashes <= 0;
            hashes_checked <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (hash_q.size() == 0)
                begin
                    $display("%0t: hash beat %08h with no string pending", $time, hash_value);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = hash_q.pop_front();
                    hashes_checked <= hashes_checked + 1;
                    if (hash_value !== want)
                    begin
                        $display("%0t: hash_value mismatch, expected %08h, actual %08h",
                                 $time, want, hash_value);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                // A terminator closes the string and restarts from zero.
                if (byte_value == TERM_BYTE)
                begin
                    hash_q.push_back(close_hash(string_hash));
                    string_hash = '0;
                end
                else
                begin
                    string_hash = absorb_byte(string_hash, byte_value);
                end
            end
            pending_hashes <= hash_q.size();
        end
    end

endmodule

// ===== tb/sv/lowercase_one_at_a_time_hash_test.sv =====
// Testbench top for the lowercase one-at-a-time hash: clock, reset, byte stimulus, verdict.
// Depends on loah_pkg, the block itself and lowercase_one_at_a_time_hash_checker.
module lowercase_one_at_a_time_hash_test;
    import loah_pkg::*;

    localparam int unsigned TIMEOUT_CYCLES = 500000;
    localparam int unsigned RANDOM_BYTES   = 1950;
    localparam int unsigned LONG_HOLD      = 300;

    logic  clk;
    logic  rst_n;
    logic  in_valid;
    logic  in_stall;
    byte_t byte_value;
    logic  out_valid;
    logic  out_stall;
    hash_t hash_value;

    int fail_count;
    int pending_hashes;
    int hashes_checked;

    int bytes_sent;
    int strings_sent;
    bit no_idle;
    bit hold_off_req;

    lowercase_one_at_a_time_hash u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .byte_value (byte_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .hash_value (hash_value)
    );

    lowercase_one_at_a_time_hash_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .byte_value     (byte_value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .hash_value     (hash_value),
        .fail_count     (fail_count),
        .pending_hashes (pending_hashes),
        .hashes_checked (hashes_checked)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    initial
    begin
        #(TIMEOUT_CYCLES * 8);
        $display("*** FAILED ***");
        $finish;
    end

    // Offer one byte after a random gap and hold it until accepted.
    task automatic send_byte(input byte_t b);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 18);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        byte_value <= b;
        do @(posedge clk); while (in_stall);
        bytes_sent++;
        if (b == TERM_BYTE)
        begin
            strings_sent++;
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_byte(byte_t'(s[i]));
        end
        send_byte(TERM_BYTE);
    endtask

    function automatic byte_t pick_char();
        int sel;
        sel = $urandom_range(0, 3);
        case (sel)
            0:       return byte_t'($urandom_range(8'h41, 8'h5A));
            1:       return byte_t'($urandom_range(8'h61, 8'h7A));
            2:       return byte_t'($urandom_range(1, 255));
            default: return byte_t'($urandom_range(8'h20, 8'h7E));
        endcase
    endfunction

    // Receiver: stall for a random gap, or a long hold-off when requested, before each result beat.
    initial
    begin
        int gap;
        out_stall <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            if (hold_off_req)
            begin
                gap = LONG_HOLD;
                hold_off_req = 1'b0;
            end
            else
            begin
                gap = no_idle ? 0 : $urandom_range(0, 18);
            end
            out_stall <= (gap != 0);
            if (gap != 0)
            begin
                repeat (gap) @(posedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!out_valid);
        end
    end

    initial
    begin
        int kind;
        int len;
        bit held;
        bit drained;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        byte_value   <= '0;
        bytes_sent   = 0;
        strings_sent = 0;
        no_idle      = 1'b0;
        hold_off_req = 1'b0;
        held         = 1'b0;
        drained      = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty string, case-map boundaries and their neighbors, high and low bytes, a mixed-case word.
        send_byte(TERM_BYTE);
        send_text("AZ");
        send_text("@[`{");
        send_text("az");
        send_byte(8'h80);
        send_byte(8'hFF);
        send_byte(8'h7F);
        send_byte(8'h01);
        send_byte(TERM_BYTE);
        send_text("HeLLo");

        while (bytes_sent < RANDOM_BYTES)
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                no_idle = !no_idle;
            end
            if (!held && bytes_sent >= 600)
            begin
                // Starve the output while bytes keep coming so the block backs up.
                held = 1'b1;
                hold_off_req = 1'b1;
                no_idle = 1'b1;
            end
            if (!drained && bytes_sent >= 1200)
            begin
                drained = 1'b1;
                in_valid <= 1'b0;
                do @(posedge clk); while (pending_hashes != 0);
            end
            kind = $urandom_range(0, 9);
            if (kind <= 6)
            begin
                len = $urandom_range(1, 12);
                repeat (len) send_byte(pick_char());
                send_byte(TERM_BYTE);
            end
            else if (kind == 7)
            begin
                len = $urandom_range(1, 6);
                repeat (len) send_byte(byte_t'($urandom_range(0, 255)));
            end
            else if (kind == 8)
            begin
                send_byte(TERM_BYTE);
            end
            else
            begin
                len = $urandom_range(20, 60);
                repeat (len) send_byte(pick_char());
                send_byte(TERM_BYTE);
            end
        end
        in_valid <= 1'b0;

        do @(posedge clk); while (pending_hashes != 0);
        repeat (10) @(posedge clk);

        $display("Sent %0d bytes forming %0d terminated strings; %0d hashes compared.",
                 bytes_sent, strings_sent, hashes_checked);
        $display("Run included a long output hold-off and a full drain pause.");
        if (fail_count == 0 && pending_hashes == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
